// File: sv/utf8v_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and byte-class constants for the UTF-8 sequence validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam int BYTE_W     = 8;
    localparam int MAX_SEQ    = 4;
    localparam int LEN_W      = 3;
    localparam int NEED_W     = 2;
    localparam int SEQ_BITS_W = BYTE_W * MAX_SEQ;
    localparam int OUT_DATA_W = 40;  // length + bytes, padded to whole bytes

    // Byte-class masks and patterns
    localparam logic [7:0] MASK_LEAD4  = 8'hF8;
    localparam logic [7:0] MASK_LEAD3  = 8'hF0;
    localparam logic [7:0] MASK_LEAD2  = 8'hE0;
    localparam logic [7:0] MASK_CONT   = 8'hC0;
    localparam logic [7:0] PAT_LEAD4   = 8'hF0;
    localparam logic [7:0] PAT_LEAD3   = 8'hE0;
    localparam logic [7:0] PAT_LEAD2   = 8'hC0;
    localparam logic [7:0] PAT_CONT    = 8'h80;
    localparam logic [7:0] OVL2_MASK   = 8'h1E;
    localparam logic [7:0] OVL4_MASK   = 8'h07;
    localparam logic [7:0] OVL4_SECOND = 8'h30;
    localparam logic [7:0] LEAD3_E0    = 8'hE0;
    localparam logic [7:0] MIN3_SECOND = 8'hA0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_END     = 2'd3
    } status_t;

    typedef struct packed {
        logic                    valid;
        status_t                 status;
        logic [LEN_W-1:0]        seq_len;
        logic [SEQ_BITS_W-1:0]   seq_bytes;
    } seq_result_t;

endpackage

// File: sv/utf8v_seq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_seq_core
// Sequence state (held bytes, counts) and the per-word decode step.
// ----------------------------------------------------------------------------
module utf8v_seq_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [utf8v_pkg::BYTE_W-1:0] data_byte,
    input  logic                        end_marker,
    output utf8v_pkg::seq_result_t      result
);
    import utf8v_pkg::*;

    logic [BYTE_W-1:0] held_reg  [MAX_SEQ];
    logic [BYTE_W-1:0] held_next [MAX_SEQ];
    logic [BYTE_W-1:0] eff       [MAX_SEQ];
    logic [NEED_W-1:0] needed_reg, needed_next;
    logic [LEN_W-1:0]  collected_reg, collected_next;
    logic              finish;
    logic [LEN_W-1:0]  fin_len;
    logic              overlong;

    always_comb begin
        held_next      = held_reg;
        eff            = held_reg;
        needed_next    = needed_reg;
        collected_next = collected_reg;
        finish         = 1'b0;
        fin_len        = '0;
        overlong       = 1'b0;
        result         = '{valid: 1'b0, status: ST_OK, seq_len: '0, seq_bytes: '0};

        if (end_marker) begin
            result.valid   = 1'b1;
            result.status  = (needed_reg != '0) ? ST_TRUNC : ST_END;
            needed_next    = '0;
            collected_next = '0;
        end else if (needed_reg == '0) begin
            eff[0]         = data_byte;
            held_next[0]   = data_byte;
            collected_next = LEN_W'(1);
            if (!data_byte[7]) begin
                finish  = 1'b1;
                fin_len = LEN_W'(1);
            end else if ((data_byte & MASK_LEAD2) == PAT_LEAD2) begin
                needed_next = NEED_W'(1);
            end else if ((data_byte & MASK_LEAD3) == PAT_LEAD3) begin
                needed_next = NEED_W'(2);
            end else if ((data_byte & MASK_LEAD4) == PAT_LEAD4) begin
                needed_next = NEED_W'(3);
            end else begin
                result.valid   = 1'b1;
                result.status  = ST_INVALID;
                collected_next = '0;
            end
        end else if ((data_byte & MASK_CONT) != PAT_CONT) begin
            result.valid   = 1'b1;
            result.status  = ST_INVALID;
            needed_next    = '0;
            collected_next = '0;
        end else begin
            eff[collected_reg[1:0]]       = data_byte;
            held_next[collected_reg[1:0]] = data_byte;
            collected_next = LEN_W'(collected_reg + LEN_W'(1));
            needed_next    = NEED_W'(needed_reg - NEED_W'(1));
            if (needed_reg == NEED_W'(1)) begin
                finish  = 1'b1;
                fin_len = collected_next;
            end
        end

        if (finish) begin
            case (fin_len)
                LEN_W'(2): overlong = (eff[0] & OVL2_MASK) == '0;
                LEN_W'(3): overlong = (eff[0] == LEAD3_E0) && (eff[1] < MIN3_SECOND);
                LEN_W'(4): overlong = ((eff[0] & OVL4_MASK) == '0)
                                   && ((eff[1] & OVL4_SECOND) == '0);
                default:   overlong = 1'b0;
            endcase
            result.valid   = 1'b1;
            needed_next    = '0;
            collected_next = '0;
            if (overlong) begin
                result.status = ST_INVALID;
            end else begin
                result.status  = ST_OK;
                result.seq_len = fin_len;
                for (int i = 0; i < MAX_SEQ; i++) begin
                    if (LEN_W'(i) < fin_len) begin
                        result.seq_bytes[i*BYTE_W +: BYTE_W] = eff[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needed_reg    <= '0;
            collected_reg <= '0;
        end else if (advance) begin
            needed_reg    <= needed_next;
            collected_reg <= collected_next;
        end
    end

    // held bytes: payload only, no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            held_reg <= held_next;
        end
    end

endmodule

// File: sv/utf8_sequence_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sequence_validator
// Groups a byte stream into UTF-8 sequences and reports each one packed with
// its length, or flags invalid, truncated and end-of-stream conditions.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                          | contents
//  --------+-----+--------------------------------+-----------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tlast | one stream byte or end mark
//  m_      | out | m_tvalid m_tready m_tdata m_tuser | sequence, status
//
//  - One word per cycle sustained while the m_ side does not stall; a word passes
//    from the input register through the decode step into the result register.
//  - Continuation bytes mid-sequence produce no output word; the completing
//    byte produces one.
//  - aresetn is synchronous, active low; it clears valid flags and the
//    sequence counters. Held bytes are not reset.
//  - A stalled m_ side holds the result register; the input register keeps
//    taking a word as long as the step behind it can advance.
// ----------------------------------------------------------------------------
module utf8_sequence_validator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [utf8v_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // end_marker
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [utf8v_pkg::OUT_DATA_W-1:0]  m_tdata,   // [2:0] sequence_length,
                                                         // [34:3] sequence_bytes,
                                                         // [39:35] zero
    output logic [1:0]                        m_tuser    // [1:0] status
);
    import utf8v_pkg::*;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;

    // result register
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg;
    logic [LEN_W-1:0]      out_len_reg;
    logic [SEQ_BITS_W-1:0] out_bytes_reg;

    logic        advance;
    seq_result_t result;

    // step the held word when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    utf8v_seq_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .data_byte  (in_byte_reg),
        .end_marker (in_end_reg),
        .result     (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance && result.valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (advance && result.valid) begin
            out_status_reg <= result.status;
            out_len_reg    <= result.seq_len;
            out_bytes_reg  <= result.seq_bytes;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(OUT_DATA_W - SEQ_BITS_W - LEN_W){1'b0}}, out_bytes_reg, out_len_reg};

endmodule
